// ----- rtl/core/sxt_pkg.sv -----
// Package with the types and constants of the s-expression tokenizer.
`default_nettype none

package sxt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_SYMBOL  = 3'd3,
    MODE_MINUS   = 3'd4
  } sxt_mode_e;

  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_END  = 2'd1,
    EV_EOF  = 2'd2
  } sxt_event_e;

  typedef enum logic [2:0] {
    TK_LPAREN = 3'd0,
    TK_RPAREN = 3'd1,
    TK_NUMBER = 3'd2,
    TK_SYMBOL = 3'd3,
    TK_QUOTE  = 3'd4
  } sxt_kind_e;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef struct packed {
    sxt_event_e ev;
    sxt_kind_e  kind;
    logic [7:0] tok_byte;
  } sxt_res_t;

  localparam sxt_res_t RES_ZERO = '{ev: EV_BYTE, kind: TK_LPAREN, tok_byte: 8'h00};

  typedef struct packed {
    logic [2:0]         cnt;
    sxt_res_t [3:0]     res;
  } sxt_bundle_t;

  typedef struct packed {
    logic       can_load;
    logic [2:0] rem;
  } sxt_emit_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/sxt_in_if.sv -----
// Input channel: one source byte or end-of-input mark per word.
`default_nettype none

interface sxt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink (input valid, input kind, input text_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sxt_out_if.sv -----
// Output channel: one token event per word.
`default_nettype none

interface sxt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [2:0] token_kind;
  logic [7:0] token_byte;
  logic       last;

  modport source (output valid, output event_res, output token_kind, output token_byte,
                  output last, input ready);
  modport sink (input valid, input event_res, input token_kind, input token_byte,
                input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sxt_decode.sv -----
// Lexer decode: next mode and the list of token events for one input word.
`default_nettype none

module sxt_decode (
  input  sxt_pkg::sxt_mode_e   mode_i,
  input  logic                 kind_i,
  input  logic [7:0]           byte_i,
  output sxt_pkg::sxt_bundle_t bundle_o,
  output sxt_pkg::sxt_mode_e   mode_o
);

  logic               is_blank;
  logic               is_dig;
  logic               ends_sym;

  logic [1:0]         st_cnt;
  sxt_pkg::sxt_res_t  st_res [2];
  sxt_pkg::sxt_mode_e st_mode;

  logic [1:0]         pre_cnt;
  sxt_pkg::sxt_res_t  pre_res [2];
  logic [1:0]         tl_cnt;
  sxt_pkg::sxt_res_t  tl_res [2];

  assign is_blank = byte_i inside {sxt_pkg::CH_SPACE, sxt_pkg::CH_TAB, sxt_pkg::CH_LF,
                                   sxt_pkg::CH_CR};
  assign is_dig   = byte_i inside {[sxt_pkg::CH_ZERO:sxt_pkg::CH_NINE]};
  assign ends_sym = byte_i inside {sxt_pkg::CH_SPACE, sxt_pkg::CH_TAB, sxt_pkg::CH_LF,
                                   sxt_pkg::CH_LPAREN, sxt_pkg::CH_RPAREN,
                                   sxt_pkg::CH_QUOTE};

  // Byte handled from idle
  always_comb begin
    st_cnt    = 2'd0;
    st_res[0] = sxt_pkg::RES_ZERO;
    st_res[1] = sxt_pkg::RES_ZERO;
    st_mode   = sxt_pkg::MODE_IDLE;
    if (is_blank) begin
      st_mode = sxt_pkg::MODE_IDLE;
    end else if (byte_i == sxt_pkg::CH_SEMI) begin
      st_mode = sxt_pkg::MODE_COMMENT;
    end else if (byte_i == sxt_pkg::CH_LPAREN) begin
      st_cnt    = 2'd2;
      st_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_LPAREN, tok_byte: byte_i};
      st_res[1] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_LPAREN, tok_byte: 8'h00};
    end else if (byte_i == sxt_pkg::CH_RPAREN) begin
      st_cnt    = 2'd2;
      st_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_RPAREN, tok_byte: byte_i};
      st_res[1] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_RPAREN, tok_byte: 8'h00};
    end else if (byte_i == sxt_pkg::CH_QUOTE) begin
      st_cnt    = 2'd2;
      st_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_QUOTE, tok_byte: byte_i};
      st_res[1] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_QUOTE, tok_byte: 8'h00};
    end else if (is_dig) begin
      st_cnt    = 2'd1;
      st_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_NUMBER, tok_byte: byte_i};
      st_mode   = sxt_pkg::MODE_NUMBER;
    end else if (byte_i == sxt_pkg::CH_MINUS) begin
      st_mode = sxt_pkg::MODE_MINUS;
    end else begin
      st_cnt    = 2'd1;
      st_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_SYMBOL, tok_byte: byte_i};
      st_mode   = sxt_pkg::MODE_SYMBOL;
    end
  end

  // Split each word into a prefix from the open token and a tail
  always_comb begin
    pre_cnt    = 2'd0;
    pre_res[0] = sxt_pkg::RES_ZERO;
    pre_res[1] = sxt_pkg::RES_ZERO;
    tl_cnt     = st_cnt;
    tl_res[0]  = st_res[0];
    tl_res[1]  = st_res[1];
    mode_o     = st_mode;
    if (kind_i == sxt_pkg::KIND_END) begin
      tl_cnt    = 2'd1;
      tl_res[0] = '{ev: sxt_pkg::EV_EOF, kind: sxt_pkg::TK_LPAREN, tok_byte: 8'h00};
      tl_res[1] = sxt_pkg::RES_ZERO;
      mode_o    = sxt_pkg::MODE_IDLE;
      case (mode_i)
        sxt_pkg::MODE_NUMBER: begin
          pre_cnt    = 2'd1;
          pre_res[0] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_NUMBER, tok_byte: 8'h00};
        end
        sxt_pkg::MODE_SYMBOL: begin
          pre_cnt    = 2'd1;
          pre_res[0] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_SYMBOL, tok_byte: 8'h00};
        end
        sxt_pkg::MODE_MINUS: begin
          pre_cnt    = 2'd2;
          pre_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_SYMBOL,
                         tok_byte: sxt_pkg::CH_MINUS};
          pre_res[1] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_SYMBOL, tok_byte: 8'h00};
        end
        default: begin
          pre_cnt = 2'd0;
        end
      endcase
    end else begin
      case (mode_i)
        sxt_pkg::MODE_COMMENT: begin
          tl_cnt = 2'd0;
          mode_o = (byte_i == sxt_pkg::CH_LF || byte_i == sxt_pkg::CH_CR) ?
                   sxt_pkg::MODE_IDLE : sxt_pkg::MODE_COMMENT;
        end
        sxt_pkg::MODE_NUMBER: begin
          if (is_dig || byte_i == sxt_pkg::CH_DOT) begin
            tl_cnt    = 2'd1;
            tl_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_NUMBER, tok_byte: byte_i};
            tl_res[1] = sxt_pkg::RES_ZERO;
            mode_o    = sxt_pkg::MODE_NUMBER;
          end else begin
            pre_cnt    = 2'd1;
            pre_res[0] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_NUMBER, tok_byte: 8'h00};
          end
        end
        sxt_pkg::MODE_SYMBOL: begin
          if (ends_sym) begin
            pre_cnt    = 2'd1;
            pre_res[0] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_SYMBOL, tok_byte: 8'h00};
          end else begin
            tl_cnt    = 2'd1;
            tl_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_SYMBOL, tok_byte: byte_i};
            tl_res[1] = sxt_pkg::RES_ZERO;
            mode_o    = sxt_pkg::MODE_SYMBOL;
          end
        end
        sxt_pkg::MODE_MINUS: begin
          if (is_dig) begin
            pre_cnt    = 2'd1;
            pre_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_NUMBER,
                           tok_byte: sxt_pkg::CH_MINUS};
            tl_cnt     = 2'd1;
            tl_res[0]  = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_NUMBER, tok_byte: byte_i};
            tl_res[1]  = sxt_pkg::RES_ZERO;
            mode_o     = sxt_pkg::MODE_NUMBER;
          end else if (ends_sym) begin
            pre_cnt    = 2'd2;
            pre_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_SYMBOL,
                           tok_byte: sxt_pkg::CH_MINUS};
            pre_res[1] = '{ev: sxt_pkg::EV_END, kind: sxt_pkg::TK_SYMBOL, tok_byte: 8'h00};
          end else begin
            pre_cnt    = 2'd1;
            pre_res[0] = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_SYMBOL,
                           tok_byte: sxt_pkg::CH_MINUS};
            tl_cnt     = 2'd1;
            tl_res[0]  = '{ev: sxt_pkg::EV_BYTE, kind: sxt_pkg::TK_SYMBOL, tok_byte: byte_i};
            tl_res[1]  = sxt_pkg::RES_ZERO;
            mode_o     = sxt_pkg::MODE_SYMBOL;
          end
        end
        default: begin
          pre_cnt = 2'd0;
        end
      endcase
    end
  end

  // Pack prefix and tail into one list
  always_comb begin
    logic [2:0] slot;
    logic [2:0] tix;
    bundle_o.cnt = 3'(pre_cnt) + 3'(tl_cnt);
    for (int i = 0; i < sxt_pkg::MaxRes; i++) begin
      slot = 3'(i);
      tix  = slot - 3'(pre_cnt);
      if (slot < 3'(pre_cnt)) begin
        bundle_o.res[i] = pre_res[slot[0]];
      end else if (tix < 3'(tl_cnt)) begin
        bundle_o.res[i] = tl_res[tix[0]];
      end else begin
        bundle_o.res[i] = sxt_pkg::RES_ZERO;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sxt_emit.sv -----
// Result register: holds the events of one word and drains them one per cycle while the output is ready.
`default_nettype none

module sxt_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  sxt_pkg::sxt_bundle_t      bundle_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output sxt_pkg::sxt_res_t         head_o,
  output logic                      last_o,
  output sxt_pkg::sxt_emit_status_t status_o
);

  logic [2:0]            rem_q;
  logic [2:0]            rem_d;
  sxt_pkg::sxt_res_t [3:0] res_q;
  sxt_pkg::sxt_res_t [3:0] res_d;
  logic                  pop;

  assign out_valid_o       = (rem_q != 3'd0);
  assign head_o            = res_q[0];
  assign last_o            = (rem_q == 3'd1);
  assign pop               = out_valid_o && out_ready_i;
  assign status_o.can_load = (rem_q == 3'd0) || (last_o && out_ready_i);
  assign status_o.rem      = rem_q;

  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    if (load_i) begin
      rem_d = bundle_i.cnt;
      res_d = bundle_i.res;
    end else if (pop) begin
      rem_d = rem_q - 3'd1;
      for (int i = 0; i < sxt_pkg::MaxRes - 1; i++) begin
        res_d[i] = res_q[i + 1];
      end
      res_d[sxt_pkg::MaxRes - 1] = sxt_pkg::RES_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/sexpr_tokenizer_top.sv -----
// Top level of the s-expression tokenizer.
`default_nettype none

// Takes Lisp source text one byte per word on in_i, with kind high for the
// end-of-input mark, and gives token events on out_o: each token byte, then a
// token-end event, and an end-of-input event for the end mark; last marks the
// final event caused by an input word. An accepted word is held in the input
// register, is decoded against the lexer mode, and its events (up to four)
// load the result register, which presents the first event on out_o. Words
// that cause zero or one event stream at one word per cycle while out_o is
// ready; a word with more events holds the result register until they drain,
// one event per cycle while out_o is ready, and the next word waits in the
// input register, stalling further input. No reset sweep is needed.
module sexpr_tokenizer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  sxt_in_if.sink    in_i,
  sxt_out_if.source out_o
);

  logic                      in_valid_q;
  logic                      kind_q;
  logic [7:0]                byte_q;
  sxt_pkg::sxt_mode_e        mode_q;
  sxt_pkg::sxt_mode_e        mode_d;
  sxt_pkg::sxt_bundle_t      bundle;
  sxt_pkg::sxt_emit_status_t emit_st;
  sxt_pkg::sxt_res_t         head;
  logic                      load;

  assign load       = in_valid_q && emit_st.can_load;
  assign in_i.ready = !in_valid_q || emit_st.can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= sxt_pkg::MODE_IDLE;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      byte_q <= in_i.text_byte;
    end
  end

  sxt_decode u_decode (
    .mode_i   (mode_q),
    .kind_i   (kind_q),
    .byte_i   (byte_q),
    .bundle_o (bundle),
    .mode_o   (mode_d)
  );

  sxt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .head_o      (head),
    .last_o      (out_o.last),
    .status_o    (emit_st)
  );

  assign out_o.event_res  = 2'(head.ev);
  assign out_o.token_kind = 3'(head.kind);
  assign out_o.token_byte = head.tok_byte;

  // Hold a decoded word until the result register takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !emit_st.can_load) |=> in_valid_q)
    else $error("input word dropped before load");

  // End mark always returns the lexer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && kind_q == sxt_pkg::KIND_END) |=> (mode_q == sxt_pkg::MODE_IDLE))
    else $error("lexer not idle after end of input");

  // End mark always yields at least its end-of-input event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && kind_q == sxt_pkg::KIND_END) |-> (bundle.cnt != 3'd0))
    else $error("end of input produced no event");

  // Pending event count never exceeds the list size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_st.rem <= 3'(sxt_pkg::MaxRes))
    else $error("event count out of range");

endmodule

`default_nettype wire
